// ===== rtl/core/assert_macros.svh =====
// Assertion helpers used by the checker file.
// Each one expects clk and rst_n in the scope where it is used.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Consequent must hold in the same cycle as the antecedent.
`define KT_ASSERT_NOW(lbl, ante, cons, msg) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error(msg);

// Consequent must hold in the cycle after the antecedent.
`define KT_ASSERT_NEXT(lbl, ante, cons, msg) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error(msg);

`endif

// ===== rtl/core/kt_pkg.sv =====
package kt_pkg;

    // Field widths of the channels
    localparam int OP_W        = 2;
    localparam int STATUS_W    = 3;
    localparam int SLOT_OUT_W  = 4;
    localparam int COUNT_OUT_W = 16;
    localparam int OCC_OUT_W   = 5;
    localparam int ACTIVE_W    = 5;

    // Operation codes
    localparam logic [OP_W-1:0] OP_INSERT = 2'd0;
    localparam logic [OP_W-1:0] OP_REMOVE = 2'd1;
    localparam logic [OP_W-1:0] OP_GET    = 2'd2;

    // Result status codes
    localparam logic [STATUS_W-1:0] ST_OK        = 3'd0;
    localparam logic [STATUS_W-1:0] ST_BAD_KEY   = 3'd1;
    localparam logic [STATUS_W-1:0] ST_FULL      = 3'd2;
    localparam logic [STATUS_W-1:0] ST_NOT_FOUND = 3'd3;
    localparam logic [STATUS_W-1:0] ST_SATURATED = 3'd4;

    // Register map
    localparam int                   REG_IDX_W        = 1;
    localparam logic [REG_IDX_W-1:0] REG_ACTIVE_SLOTS = 1'b0;
    localparam logic [ACTIVE_W-1:0]  ACTIVE_RESET     = 5'd16;

    // Command broadcast to every cell in the update cycle
    typedef struct packed {
        logic apply;
        logic ins;
        logic rem;
    } kt_cmd_t;

    // Priority flags handed from one cell to the next
    typedef struct packed {
        logic match_seen;
        logic free_seen;
    } kt_chain_t;

endpackage

// ===== rtl/core/kt_req_if.sv =====
interface kt_req_if #(
    parameter int KEY_BITS = 32
);
    import kt_pkg::*;

    logic                valid;
    logic                ready;
    logic [OP_W-1:0]     operation;
    logic [KEY_BITS-1:0] key;

    modport source (output valid, operation, key, input ready);
    modport sink (input valid, operation, key, output ready);
endinterface

// ===== rtl/core/kt_rsp_if.sv =====
interface kt_rsp_if;
    import kt_pkg::*;

    logic                   valid;
    logic                   ready;
    logic [STATUS_W-1:0]    status;
    logic                   hit;
    logic [SLOT_OUT_W-1:0]  slot;
    logic [COUNT_OUT_W-1:0] use_count;
    logic                   released;
    logic [OCC_OUT_W-1:0]   occupied;

    modport source (output valid, status, hit, slot, use_count, released, occupied,
                    input ready);
    modport sink (input valid, status, hit, slot, use_count, released, occupied,
                  output ready);
endinterface

// ===== rtl/core/kt_cell.sv =====
module kt_cell
    import kt_pkg::*;
#(
    parameter int IDX        = 0,
    parameter int IDX_W      = 4,
    parameter int KEY_BITS   = 32,
    parameter int COUNT_BITS = 16
) (
    input  logic                  clk,
    input  logic                  rst_n,
    input  logic [ACTIVE_W-1:0]   active_slots,
    input  logic [KEY_BITS-1:0]   key,
    input  logic                  cmp_en,
    input  kt_cmd_t               cmd,
    input  logic                  hit_all,
    input  kt_chain_t             chain_in,
    input  logic [COUNT_BITS-1:0] cnt_in,
    input  logic [IDX_W-1:0]      midx_in,
    input  logic [IDX_W-1:0]      fidx_in,
    output kt_chain_t             chain_out,
    output logic [COUNT_BITS-1:0] cnt_out,
    output logic [IDX_W-1:0]      midx_out,
    output logic [IDX_W-1:0]      fidx_out
);

    localparam logic [COUNT_BITS-1:0] CNT_MAX = '1;
    localparam logic [COUNT_BITS-1:0] CNT_ONE = COUNT_BITS'(1);
    localparam logic [IDX_W-1:0]      MY_IDX  = IDX_W'(IDX);

    logic                  valid_reg;
    logic [KEY_BITS-1:0]   key_reg;
    logic [COUNT_BITS-1:0] count_reg;
    logic                  match_reg;
    logic                  free_reg;
    logic                  in_range;
    logic                  take_match;
    logic                  take_free;

    assign in_range = 32'(active_slots) > 32'(IDX);

    // First match and first free slot win; later cells see the flags set
    assign take_match = match_reg && !chain_in.match_seen;
    assign take_free  = free_reg && !chain_in.free_seen;

    assign chain_out.match_seen = chain_in.match_seen | match_reg;
    assign chain_out.free_seen  = chain_in.free_seen | free_reg;
    assign cnt_out  = take_match ? count_reg : cnt_in;
    assign midx_out = take_match ? MY_IDX : midx_in;
    assign fidx_out = take_free ? MY_IDX : fidx_in;

    // Compare and update the slot
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            valid_reg <= 1'b0;
            count_reg <= '0;
            match_reg <= 1'b0;
            free_reg  <= 1'b0;
        end
        else
        begin
            if (cmp_en)
            begin
                match_reg <= valid_reg && in_range && (key_reg == key);
                free_reg  <= !valid_reg && in_range;
            end
            if (cmd.apply && cmd.ins)
            begin
                if (take_match && count_reg != CNT_MAX)
                begin
                    count_reg <= count_reg + CNT_ONE;
                end
                else if (!hit_all && take_free)
                begin
                    valid_reg <= 1'b1;
                    count_reg <= CNT_ONE;
                end
            end
            if (cmd.apply && cmd.rem && take_match)
            begin
                if (count_reg <= CNT_ONE)
                begin
                    valid_reg <= 1'b0;
                    count_reg <= '0;
                end
                else
                begin
                    count_reg <= count_reg - CNT_ONE;
                end
            end
        end
    end

    // Load the key when a free slot is taken
    always_ff @(posedge clk)
    begin
        if (cmd.apply && cmd.ins && !hit_all && take_free)
        begin
            key_reg <= key;
        end
    end

endmodule

// ===== rtl/core/refcounted_key_table.sv =====
// Reference-counted key table.
// req channel: one beat carries an operation (insert, remove, get) and a key.
// rsp channel: one beat per request with status, hit, slot, use count,
// released flag and the number of occupied slots after the operation.
// APB port: register 0 (active_slots) limits how many slots are searched and
// taken; write it only while no request is in flight.
// Each request passes the parallel key compare in every cell (S_CMP), then the
// priority pass along the cell chain and the count update (S_UPD); the result
// is then registered into the rsp beat. The next req beat is taken in the
// update cycle of the current one, so the table takes a new request while it
// stores the result of the last one.
// The result sits in an output register: a stalled rsp holds its beat, the
// pending request waits in its update cycle and no table state changes
// until the result can be stored.
// Reset: all slots free, all counts zero, occupied zero, active_slots 16.
module refcounted_key_table
    import kt_pkg::*;
#(
    parameter int SLOTS      = 16,
    parameter int KEY_BITS   = 32,
    parameter int COUNT_BITS = 16
) (
    input  logic                      clk,
    input  logic                      rst_n,
    input  logic                      psel,
    input  logic                      penable,
    input  logic                      pwrite,
    input  logic [REG_IDX_W+1:0]      paddr,
    input  logic [31:0]               pwdata,
    output logic [31:0]               prdata,
    output logic                      pready,
    kt_req_if.sink                    req,
    kt_rsp_if.source                  rsp
);

    localparam int IDX_W = $clog2(SLOTS);
    localparam int OCC_W = $clog2(SLOTS + 1);
    localparam logic [COUNT_BITS-1:0] CNT_MAX = '1;
    localparam logic [COUNT_BITS-1:0] CNT_ONE = COUNT_BITS'(1);
    localparam logic [OCC_W-1:0]      OCC_ONE = OCC_W'(1);

    typedef enum logic [1:0] {
        S_IDLE,
        S_CMP,
        S_UPD
    } state_t;

    state_t                 state_reg;
    logic [OP_W-1:0]        op_reg;
    logic [KEY_BITS-1:0]    key_reg;
    logic [OCC_W-1:0]       occ_reg;
    logic [ACTIVE_W-1:0]    active_reg;
    logic                   rsp_valid_reg;
    logic [STATUS_W-1:0]    rsp_status_reg;
    logic                   rsp_hit_reg;
    logic [SLOT_OUT_W-1:0]  rsp_slot_reg;
    logic [COUNT_OUT_W-1:0] rsp_cnt_reg;
    logic                   rsp_rel_reg;
    logic [OCC_OUT_W-1:0]   rsp_occ_reg;

    logic                   advance;
    logic                   accept;
    logic                   key_nz;
    logic                   cmp_en;
    kt_cmd_t                cmd;

    kt_chain_t              chain  [0:SLOTS];
    logic [COUNT_BITS-1:0]  cnt_ch [0:SLOTS];
    logic [IDX_W-1:0]       midx_ch[0:SLOTS];
    logic [IDX_W-1:0]       fidx_ch[0:SLOTS];

    logic [STATUS_W-1:0]    res_status;
    logic                   res_hit;
    logic [IDX_W-1:0]       res_slot;
    logic [COUNT_BITS-1:0]  res_cnt;
    logic                   res_rel;
    logic [OCC_W-1:0]       occ_next;

    // APB register port
    assign pready = 1'b1;
    assign prdata = (paddr[REG_IDX_W+1:2] == REG_ACTIVE_SLOTS) ? 32'(active_reg) : '0;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            active_reg <= ACTIVE_RESET;
        end
        else if (psel && penable && pwrite && pready
                 && paddr[REG_IDX_W+1:2] == REG_ACTIVE_SLOTS)
        begin
            active_reg <= pwdata[ACTIVE_W-1:0];
        end
    end

    // Handshake and cell control
    assign advance   = !rsp_valid_reg || rsp.ready;
    assign req.ready = (state_reg == S_IDLE) || (state_reg == S_UPD && advance);
    assign accept    = req.valid && req.ready;
    assign key_nz    = key_reg != '0;
    assign cmp_en    = state_reg == S_CMP;
    assign cmd.apply = (state_reg == S_UPD) && advance && key_nz;
    assign cmd.ins   = op_reg == OP_INSERT;
    assign cmd.rem   = op_reg == OP_REMOVE;

    // Chain of slot cells
    assign chain[0]   = '0;
    assign cnt_ch[0]  = '0;
    assign midx_ch[0] = '0;
    assign fidx_ch[0] = '0;

    for (genvar i = 0; i < SLOTS; i++)
    begin : g_cell
        kt_cell #(
            .IDX        (i),
            .IDX_W      (IDX_W),
            .KEY_BITS   (KEY_BITS),
            .COUNT_BITS (COUNT_BITS)
        ) u_cell (
            .clk          (clk),
            .rst_n        (rst_n),
            .active_slots (active_reg),
            .key          (key_reg),
            .cmp_en       (cmp_en),
            .cmd          (cmd),
            .hit_all      (chain[SLOTS].match_seen),
            .chain_in     (chain[i]),
            .cnt_in       (cnt_ch[i]),
            .midx_in      (midx_ch[i]),
            .fidx_in      (fidx_ch[i]),
            .chain_out    (chain[i+1]),
            .cnt_out      (cnt_ch[i+1]),
            .midx_out     (midx_ch[i+1]),
            .fidx_out     (fidx_ch[i+1])
        );
    end

    // Build the result from the end of the chain
    always_comb
    begin
        res_status = ST_OK;
        res_hit    = 1'b0;
        res_slot   = '0;
        res_cnt    = '0;
        res_rel    = 1'b0;
        occ_next   = occ_reg;
        if (!key_nz)
        begin
            res_status = ST_BAD_KEY;
        end
        else
        begin
            case (op_reg)
                OP_INSERT:
                begin
                    if (chain[SLOTS].match_seen)
                    begin
                        res_hit  = 1'b1;
                        res_slot = midx_ch[SLOTS];
                        if (cnt_ch[SLOTS] == CNT_MAX)
                        begin
                            res_status = ST_SATURATED;
                            res_cnt    = cnt_ch[SLOTS];
                        end
                        else
                        begin
                            res_cnt = cnt_ch[SLOTS] + CNT_ONE;
                        end
                    end
                    else if (chain[SLOTS].free_seen)
                    begin
                        res_slot = fidx_ch[SLOTS];
                        res_cnt  = CNT_ONE;
                        occ_next = occ_reg + OCC_ONE;
                    end
                    else
                    begin
                        res_status = ST_FULL;
                    end
                end
                OP_REMOVE:
                begin
                    if (chain[SLOTS].match_seen)
                    begin
                        res_hit  = 1'b1;
                        res_slot = midx_ch[SLOTS];
                        if (cnt_ch[SLOTS] <= CNT_ONE)
                        begin
                            res_rel = 1'b1;
                            if (occ_reg != '0)
                            begin
                                occ_next = occ_reg - OCC_ONE;
                            end
                        end
                        else
                        begin
                            res_cnt = cnt_ch[SLOTS] - CNT_ONE;
                        end
                    end
                    else
                    begin
                        res_status = ST_NOT_FOUND;
                    end
                end
                default:
                begin
                    // get, and the unused code that behaves as get
                    if (chain[SLOTS].match_seen)
                    begin
                        res_hit  = 1'b1;
                        res_slot = midx_ch[SLOTS];
                        res_cnt  = cnt_ch[SLOTS];
                    end
                    else
                    begin
                        res_status = ST_NOT_FOUND;
                    end
                end
            endcase
        end
    end

    // Sequencer, request capture, occupancy and output register
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg      <= S_IDLE;
            op_reg         <= '0;
            key_reg        <= '0;
            occ_reg        <= '0;
            rsp_valid_reg  <= 1'b0;
            rsp_status_reg <= '0;
            rsp_hit_reg    <= 1'b0;
            rsp_slot_reg   <= '0;
            rsp_cnt_reg    <= '0;
            rsp_rel_reg    <= 1'b0;
            rsp_occ_reg    <= '0;
        end
        else
        begin
            // drop a taken beat unless the update cycle refills the register
            if (rsp_valid_reg && rsp.ready && state_reg != S_UPD)
            begin
                rsp_valid_reg <= 1'b0;
            end
            if (accept)
            begin
                op_reg  <= req.operation;
                key_reg <= req.key;
            end
            case (state_reg)
                S_IDLE:
                begin
                    if (accept)
                    begin
                        state_reg <= S_CMP;
                    end
                end
                S_CMP:
                begin
                    state_reg <= S_UPD;
                end
                S_UPD:
                begin
                    if (advance)
                    begin
                        occ_reg        <= occ_next;
                        rsp_valid_reg  <= 1'b1;
                        rsp_status_reg <= res_status;
                        rsp_hit_reg    <= res_hit;
                        rsp_slot_reg   <= SLOT_OUT_W'(res_slot);
                        rsp_cnt_reg    <= COUNT_OUT_W'(res_cnt);
                        rsp_rel_reg    <= res_rel;
                        rsp_occ_reg    <= OCC_OUT_W'(occ_next);
                        state_reg      <= accept ? S_CMP : S_IDLE;
                    end
                end
                default:
                begin
                    state_reg <= S_IDLE;
                end
            endcase
        end
    end

    assign rsp.valid     = rsp_valid_reg;
    assign rsp.status    = rsp_status_reg;
    assign rsp.hit       = rsp_hit_reg;
    assign rsp.slot      = rsp_slot_reg;
    assign rsp.use_count = rsp_cnt_reg;
    assign rsp.released  = rsp_rel_reg;
    assign rsp.occupied  = rsp_occ_reg;

endmodule

// ===== rtl/core/kt_checker.sv =====
`include "assert_macros.svh"

module kt_checker
    import kt_pkg::*;
(
    input logic                   clk,
    input logic                   rst_n,
    input logic                   req_valid,
    input logic                   req_ready,
    input logic                   rsp_valid,
    input logic                   rsp_ready,
    input logic [STATUS_W-1:0]    rsp_status,
    input logic                   rsp_hit,
    input logic [SLOT_OUT_W-1:0]  rsp_slot,
    input logic [COUNT_OUT_W-1:0] rsp_use_count,
    input logic                   rsp_released
);

    // A stalled result beat holds
    `KT_ASSERT_NEXT(a_rsp_hold, rsp_valid && !rsp_ready,
        rsp_valid && $stable(rsp_status) && $stable(rsp_use_count), "rsp beat dropped")

    // One request at a time through the compare cycle
    `KT_ASSERT_NEXT(a_req_gap, req_valid && req_ready, !req_ready, "request taken during compare")

    // A zero key leaves hit, slot, use count and released clear
    `KT_ASSERT_NOW(a_bad_key, rsp_valid && rsp_status == ST_BAD_KEY,
        !rsp_hit && rsp_slot == '0 && rsp_use_count == '0 && !rsp_released,
        "zero key result not clear")

    // Freeing a slot is a hit with a zero count
    `KT_ASSERT_NOW(a_release, rsp_valid && rsp_released,
        rsp_status == ST_OK && rsp_hit && rsp_use_count == '0, "bad release result")

    // A miss reports no count unless a new slot was taken
    `KT_ASSERT_NOW(a_miss_count, rsp_valid && !rsp_hit,
        rsp_use_count == '0 || (rsp_status == ST_OK && rsp_use_count == COUNT_OUT_W'(1)),
        "count reported on a miss")

endmodule

bind refcounted_key_table kt_checker u_kt_checker (
    .clk           (clk),
    .rst_n         (rst_n),
    .req_valid     (req.valid),
    .req_ready     (req.ready),
    .rsp_valid     (rsp.valid),
    .rsp_ready     (rsp.ready),
    .rsp_status    (rsp.status),
    .rsp_hit       (rsp.hit),
    .rsp_slot      (rsp.slot),
    .rsp_use_count (rsp.use_count),
    .rsp_released  (rsp.released)
);
